// ===== src/ubs_pkg.sv =====
// ----------------------------------------------------------------------------
// ubs_pkg
// Shared constants for the uniform B-spline evaluator.
// ----------------------------------------------------------------------------
package ubs_pkg;
  localparam int MaxPoints = 256;
  localparam int MaxDegree = 7;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int DegW = $clog2(MaxDegree + 1);
  localparam int NFields = 5;
  localparam int DataW = 32;
  localparam int FracW = 24;
  localparam int PtW = NFields * DataW;

  localparam logic [1:0] RegPointCount = 2'd0;
  localparam logic [1:0] RegClosedLoop = 2'd1;
  localparam logic [1:0] RegDegree = 2'd2;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdSample = 1'b1;
endpackage

// ===== src/uniform_bspline_de_boor_eval_top.sv =====
// ----------------------------------------------------------------------------
// uniform_bspline_de_boor_eval_top
// Uniform B-spline evaluation by de Boor's recurrence over a point RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   cmd=0 writes one control point (x, y, z, scale, azimuth) into the point
//   RAM at that edge; no result beat follows and busy stays low, so writes
//   can follow each other back to back.
//   cmd=1 samples the curve at t_fraction: busy rises, the block sets up the
//   knot span (setup, multiply, knot states), reads degree+1 points from the
//   registered-read RAM, then runs degree*(degree+1)/2 lerps, each through the
//   weight, divide by reciprocal multiply, multiply and sum states, and
//   ends in an output state; an empty store goes straight to that state,
//   and its beat carries no_points. done is high for one cycle as busy
//   falls; the next item can be taken at the edge that ends it, so a new
//   sample waits until the last one is done. The lerp loop sets the rate.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge and belong in idle time. Reset idles the block, clears busy,
//   done and the point count, and sets a closed loop of degree 3; the RAM
//   holds garbage until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module uniform_bspline_de_boor_eval_top
  import ubs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CntW-1:0]         cfg_data,
  input  logic                    cmd,
  input  logic [7:0]              point_index,
  input  logic signed [DataW-1:0] in_x,
  input  logic signed [DataW-1:0] in_y,
  input  logic signed [DataW-1:0] in_z,
  input  logic signed [DataW-1:0] in_scale,
  input  logic signed [DataW-1:0] in_azimuth,
  input  logic [FracW-1:0]        t_fraction,
  output logic                    done,
  output logic signed [DataW-1:0] out_x,
  output logic signed [DataW-1:0] out_y,
  output logic signed [DataW-1:0] out_z,
  output logic signed [DataW-1:0] out_scale,
  output logic signed [DataW-1:0] out_azimuth,
  output logic                    no_points
);
  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_MUL, S_KNOT, S_FETCH, S_LERP_W, S_DIV, S_LERP_M,
    S_LERP_S, S_DONE
  } state_t;

  localparam int TW = FracW + CntW + 1;
  // ceil(2^32 / 2d) for the odd and non-power-of-two divisors
  localparam logic [31:0] Recip3 = 32'(((64'd1 << 32) + 64'd5) / 64'd6);
  localparam logic [31:0] Recip5 = 32'(((64'd1 << 32) + 64'd9) / 64'd10);
  localparam logic [31:0] Recip6 = 32'(((64'd1 << 32) + 64'd11) / 64'd12);
  localparam logic [31:0] Recip7 = 32'(((64'd1 << 32) + 64'd13) / 64'd14);

  state_t state;
  logic [CntW-1:0] point_count;
  logic closed_loop;
  logic [DegW-1:0] spline_degree;

  logic [CntW-1:0] m;
  logic [DegW-1:0] deg;
  logic [CntW:0] span;
  logic [FracW-1:0] frac;
  logic [TW-1:0] tfix;
  logic [CntW:0] slot;
  logic [DegW:0] fcnt, rcnt;
  logic [DegW-1:0] pw, li;
  logic [3:0] dd;
  logic [FracW+2:0] num;
  logic [FracW+1:0] w;
  logic [FracW+3:0] dnum;
  logic [31:0] recip;
  logic [FracW+35:0] qprod;
  logic [DataW-1:0] pts [NFields][MaxDegree+1];
  logic signed [63:0] prod0 [NFields];
  logic signed [63:0] prod1 [NFields];

  logic ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [PtW-1:0] ram_wdata, ram_rdata;

  assign ram_we = start && !busy && cmd == CmdWrite;
  assign ram_wdata = {in_azimuth, in_scale, in_z, in_y, in_x};

  ubs_ram #(.Width(PtW), .Depth(MaxPoints)) u_ram (
    .clk(clk), .we(ram_we), .waddr(point_index[AddrW-1:0]), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // slot wraps modulo m; slot <= m holds throughout the fetch
  assign ram_raddr = (slot >= {1'b0, m}) ? AddrW'(slot - {1'b0, m}) : AddrW'(slot);

  // weight = floor((2*anum + d) / (2*d))
  assign dnum = {num, 1'b0} + (FracW+4)'(dd);
  assign qprod = (FracW+36)'(dnum) * (FracW+36)'(recip);

  always_comb begin
    case (dd)
      4'd3: recip = Recip3;
      4'd5: recip = Recip5;
      4'd6: recip = Recip6;
      4'd7: recip = Recip7;
      default: recip = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      point_count <= '0;
      closed_loop <= 1'b1;
      spline_degree <= DegW'(3);
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) begin
        case (cfg_index)
          RegPointCount: point_count <= cfg_data;
          RegClosedLoop: closed_loop <= cfg_data[0];
          RegDegree: spline_degree <= cfg_data[DegW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start && cmd == CmdSample) begin
            busy <= 1'b1;
            frac <= t_fraction;
            m <= (point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (m == '0) begin
            out_x <= '0; out_y <= '0; out_z <= '0; out_scale <= '0;
            out_azimuth <= '0; no_points <= 1'b1;
            state <= S_DONE;
          end else begin
            if (closed_loop) begin
              deg <= spline_degree;
              span <= (CntW+1)'(m);
            end else if ((CntW+1)'(spline_degree) >= (CntW+1)'(m)) begin
              deg <= DegW'(m - 1'b1);
              span <= (CntW+1)'(1);
            end else begin
              deg <= spline_degree;
              span <= (CntW+1)'(m) - (CntW+1)'(spline_degree);
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          tfix <= TW'({deg, {FracW{1'b0}}}) + TW'(frac) * TW'(span);
          state <= S_KNOT;
        end
        S_KNOT: begin
          // start slot = k - deg, already below m
          slot <= (CntW+1)'(tfix[TW-1:FracW] - (TW-FracW)'(deg));
          fcnt <= '0;
          rcnt <= '0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (fcnt <= (DegW+1)'(deg)) begin
            slot <= ((slot >= {1'b0, m}) ? slot - {1'b0, m} : slot) + 1'b1;
            fcnt <= fcnt + 1'b1;
          end
          if (fcnt != '0) begin
            for (int f = 0; f < NFields; f++) begin
              pts[f][rcnt[DegW-1:0]] <= ram_rdata[f*DataW +: DataW];
            end
            rcnt <= rcnt + 1'b1;
            if (rcnt == (DegW+1)'(deg)) begin
              pw <= DegW'(1);
              li <= '0;
              state <= (deg == '0) ? S_LERP_S : S_LERP_W;
            end
          end
        end
        S_LERP_W: begin
          dd <= 4'(deg - pw) + 4'd1;
          // anum = tfix - (k-deg+pw+li)<<24, in [0, d*2^24)
          num <= (FracW+3)'(tfix[FracW-1:0]) +
                 (FracW+3)'({3'(deg - pw - li), {FracW{1'b0}}});
          state <= S_DIV;
        end
        S_DIV: begin
          case (dd)
            4'd1: w <= (FracW+2)'(num);
            4'd2: w <= (FracW+2)'((num + 1'b1) >> 1);
            4'd4: w <= (FracW+2)'((num + 2'd2) >> 2);
            4'd8: w <= (FracW+2)'((num + 3'd4) >> 3);
            default: w <= (FracW+2)'(qprod[FracW+35:32]);
          endcase
          state <= S_LERP_M;
        end
        S_LERP_M: begin
          for (int f = 0; f < NFields; f++) begin
            prod0[f] <= $signed(pts[f][li]) *
                        $signed({1'b0, (FracW+1)'((1 << FracW) - w)});
            prod1[f] <= $signed(pts[f][li+1'b1]) * $signed({1'b0, w[FracW:0]});
          end
          state <= S_LERP_S;
        end
        S_LERP_S: begin
          if (deg != '0) begin
            for (int f = 0; f < NFields; f++) begin
              pts[f][li] <= DataW'((prod0[f] + prod1[f] + 64'sd8388608) >>> FracW);
            end
          end
          if (deg == '0 || (pw == deg && li == '0)) begin
            state <= S_DONE;
            no_points <= 1'b0;
          end else if (li == deg - pw) begin
            pw <= pw + 1'b1;
            li <= '0;
            state <= S_LERP_W;
          end else begin
            li <= li + 1'b1;
            state <= S_LERP_W;
          end
        end
        S_DONE: begin
          if (!no_points || m != '0) begin
            out_x <= pts[0][0]; out_y <= pts[1][0]; out_z <= pts[2][0];
            out_scale <= pts[3][0]; out_azimuth <= pts[4][0];
          end
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_LERP_S on the last lerp writes pts before S_DONE copies it.

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_no_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy)
    else $error("busy in idle");
endmodule

// ===== src/ubs_ram.sv =====
// ----------------------------------------------------------------------------
// ubs_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ubs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
